FILE: sv/owm_pkg.sv
`timescale 1ns / 1ps

package owm_pkg;

	// Command codes carried by req_type.
	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_RESET = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_READ  = 3'd3;
	localparam logic [2:0] REQ_WAIT  = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_RESET_LOW      = 3'd0;
	localparam logic [2:0] CFG_PRESENCE_DELAY = 3'd1;
	localparam logic [2:0] CFG_PRESENCE_POLLS = 3'd2;
	localparam logic [2:0] CFG_POLL_TICKS     = 3'd3;
	localparam logic [2:0] CFG_SLOT           = 3'd4;
	localparam logic [2:0] CFG_WRITE_ONE_LOW  = 3'd5;
	localparam logic [2:0] CFG_READ_SAMPLE    = 3'd6;
	localparam logic [2:0] CFG_RECOVERY       = 3'd7;

	localparam int CFG_DATA_W = 10;

	// Bus sequencer phases.
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_POLL = 4'd3;
	localparam logic [3:0] PH_WR_SLOT  = 4'd4;
	localparam logic [3:0] PH_WR_REC   = 4'd5;
	localparam logic [3:0] PH_RD_SLOT  = 4'd6;
	localparam logic [3:0] PH_RD_REC   = 4'd7;
	localparam logic [3:0] PH_WT_SLOT  = 4'd8;
	localparam logic [3:0] PH_WT_REC   = 4'd9;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] write_data;
		logic [7:0] byte_count;
		logic       line_in;
	} owm_req_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       last_byte;
	} owm_res_t;

	typedef struct packed {
		logic [9:0] reset_low_ticks;
		logic [7:0] presence_delay_ticks;
		logic [5:0] presence_polls;
		logic [5:0] presence_poll_ticks;
		logic [7:0] slot_ticks;
		logic [5:0] write_one_low_ticks;
		logic [5:0] read_sample_ticks;
		logic [3:0] recovery_ticks;
	} owm_cfg_t;

endpackage

FILE: sv/owm_req_if.sv
`timescale 1ns / 1ps

interface owm_req_if;
	logic              valid;
	logic              ready;
	owm_pkg::owm_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/owm_res_if.sv
`timescale 1ns / 1ps

interface owm_res_if;
	logic              valid;
	logic              ready;
	owm_pkg::owm_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/owm_cfg_regs.sv
`timescale 1ns / 1ps

module owm_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [owm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output owm_pkg::owm_cfg_t                  cfg
);
	import owm_pkg::*;

	owm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks      <= 10'd480;
			cfg_q.presence_delay_ticks <= 8'd60;
			cfg_q.presence_polls       <= 6'd18;
			cfg_q.presence_poll_ticks  <= 6'd10;
			cfg_q.slot_ticks           <= 8'd60;
			cfg_q.write_one_low_ticks  <= 6'd15;
			cfg_q.read_sample_ticks    <= 6'd15;
			cfg_q.recovery_ticks       <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RESET_LOW:      cfg_q.reset_low_ticks      <= cfg_data[9:0];
				CFG_PRESENCE_DELAY: cfg_q.presence_delay_ticks <= cfg_data[7:0];
				CFG_PRESENCE_POLLS: cfg_q.presence_polls       <= cfg_data[5:0];
				CFG_POLL_TICKS:     cfg_q.presence_poll_ticks  <= cfg_data[5:0];
				CFG_SLOT:           cfg_q.slot_ticks           <= cfg_data[7:0];
				CFG_WRITE_ONE_LOW:  cfg_q.write_one_low_ticks  <= cfg_data[5:0];
				CFG_READ_SAMPLE:    cfg_q.read_sample_ticks    <= cfg_data[5:0];
				CFG_RECOVERY:       cfg_q.recovery_ticks       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/owm_core.sv
`timescale 1ns / 1ps

module owm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  owm_pkg::owm_req_t  item,
	input  owm_pkg::owm_cfg_t  cfg,
	output owm_pkg::owm_res_t  res
);
	import owm_pkg::*;

	localparam logic [1:0] KIND_WR = 2'd0;
	localparam logic [1:0] KIND_RD = 2'd1;
	localparam logic [1:0] KIND_WT = 2'd2;

	logic [3:0] phase_q;
	logic [9:0] timer_q;
	logic [2:0] bit_q;
	logic [7:0] shift_q;
	logic [7:0] left_q;
	logic [5:0] polls_q;
	logic       presence_q;

	logic [3:0] ph;
	logic [9:0] tt;
	logic [2:0] bi;
	logic [7:0] sh;
	logic [7:0] bl;
	logic [5:0] pc;
	logic       pf;
	logic       done;
	logic       busy;
	logic       drive;
	logic       valid;
	logic       last;
	logic [7:0] rbyte;
	logic       do_gap;
	logic [1:0] kind;
	logic       finished;
	logic       poll_end;
	logic [7:0] low_len;
	logic [7:0] slot_len;
	logic [7:0] sample_pt;

	// Sample point is clamped to the last tick of the slot.
	always_comb begin
		slot_len  = (cfg.slot_ticks != 8'd0) ? cfg.slot_ticks : 8'd1;
		sample_pt = ({2'b00, cfg.read_sample_ticks} >= slot_len) ?
			slot_len - 8'd1 : {2'b00, cfg.read_sample_ticks};
	end

	always_comb begin
		ph       = phase_q;
		tt       = timer_q;
		bi       = bit_q;
		sh       = shift_q;
		bl       = left_q;
		pc       = polls_q;
		pf       = presence_q;
		done     = 1'b0;
		drive    = 1'b0;
		valid    = 1'b0;
		last     = 1'b0;
		rbyte    = 8'd0;
		do_gap   = 1'b0;
		kind     = KIND_WR;
		finished = 1'b0;
		poll_end = 1'b0;
		low_len  = 8'd0;

		// A command starts only while idle; its accepting tick runs its first phase.
		if (ph == PH_IDLE) begin
			tt = 10'd0;
			case (item.req_type)
				REQ_RESET: begin
					ph = PH_RST_LOW;
				end
				REQ_WRITE: begin
					sh = item.write_data;
					bi = 3'd0;
					bl = 8'd1;
					ph = PH_WR_SLOT;
				end
				REQ_READ: begin
					sh = 8'd0;
					bi = 3'd0;
					bl = item.byte_count;
					if (item.byte_count == 8'd0) begin
						done = 1'b1;
					end else begin
						ph = PH_RD_SLOT;
					end
				end
				REQ_WAIT: begin
					sh = 8'd0;
					ph = PH_WT_SLOT;
				end
				default: ;
			endcase
		end
		busy = (ph != PH_IDLE) || done;

		case (ph)
			PH_IDLE: ;
			PH_RST_LOW: begin
				drive = 1'b1;
				tt = tt + 10'd1;
				if (tt >= cfg.reset_low_ticks) begin
					ph = PH_RST_WAIT;
					tt = 10'd0;
				end
			end
			PH_RST_WAIT: begin
				tt = tt + 10'd1;
				if (tt >= {2'b00, cfg.presence_delay_ticks}) begin
					ph = PH_RST_POLL;
					tt = 10'd0;
					pc = 6'd0;
				end
			end
			PH_RST_POLL: begin
				if (tt == 10'd0) begin
					if (!item.line_in) begin
						pf = 1'b1;
						ph = PH_IDLE;
						done = 1'b1;
						poll_end = 1'b1;
					end else begin
						pc = pc + 6'd1;
						if (pc == 6'd0 || pc >= cfg.presence_polls) begin
							pf = 1'b0;
							ph = PH_IDLE;
							done = 1'b1;
							poll_end = 1'b1;
						end
					end
				end
				if (!poll_end) begin
					tt = tt + 10'd1;
					if (tt >= {4'b0000, cfg.presence_poll_ticks}) begin
						tt = 10'd0;
					end
				end
			end
			PH_WR_SLOT: begin
				low_len = sh[0] ? {2'b00, cfg.write_one_low_ticks} : cfg.slot_ticks;
				drive = (tt < {2'b00, low_len}) || (tt == 10'd0);
				tt = tt + 10'd1;
				if (tt >= {2'b00, cfg.slot_ticks}) begin
					sh = {1'b0, sh[7:1]};
					if (bi == 3'd7) begin
						bl = 8'd0;
					end
					bi = bi + 3'd1;
					tt = 10'd0;
					kind = KIND_WR;
					if (cfg.recovery_ticks == 4'd0) begin
						do_gap = 1'b1;
					end else begin
						ph = PH_WR_REC;
					end
				end
			end
			PH_RD_SLOT, PH_WT_SLOT: begin
				drive = (tt == 10'd0);
				if (tt == {2'b00, sample_pt}) begin
					if (ph == PH_RD_SLOT) begin
						sh = {item.line_in, sh[7:1]};
					end else begin
						sh = {item.line_in, 7'd0};
					end
				end
				tt = tt + 10'd1;
				if (tt >= {2'b00, cfg.slot_ticks}) begin
					if (ph == PH_WT_SLOT) begin
						kind = KIND_WT;
						tt = 10'd0;
						if (cfg.recovery_ticks == 4'd0) begin
							do_gap = 1'b1;
						end else begin
							ph = PH_WT_REC;
						end
					end else begin
						if (bi == 3'd7) begin
							valid = 1'b1;
							rbyte = sh;
							last = (bl <= 8'd1);
							if (bl != 8'd0) begin
								bl = bl - 8'd1;
							end
							sh = 8'd0;
						end
						bi = bi + 3'd1;
						kind = KIND_RD;
						tt = 10'd0;
						if (cfg.recovery_ticks == 4'd0) begin
							do_gap = 1'b1;
						end else begin
							ph = PH_RD_REC;
						end
					end
				end
			end
			PH_WR_REC, PH_RD_REC, PH_WT_REC: begin
				tt = tt + 10'd1;
				kind = (ph == PH_WR_REC) ? KIND_WR : (ph == PH_RD_REC) ? KIND_RD : KIND_WT;
				if (tt >= {6'd0, cfg.recovery_ticks}) begin
					do_gap = 1'b1;
				end
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase

		// After the recovery gap, either start the next slot or finish the command.
		if (do_gap) begin
			tt = 10'd0;
			finished = (kind == KIND_WT) ? sh[7] : (bl == 8'd0);
			if (finished) begin
				ph = PH_IDLE;
				done = 1'b1;
			end else begin
				ph = (kind == KIND_WR) ? PH_WR_SLOT :
					(kind == KIND_RD) ? PH_RD_SLOT : PH_WT_SLOT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			timer_q    <= 10'd0;
			bit_q      <= 3'd0;
			shift_q    <= 8'd0;
			left_q     <= 8'd0;
			polls_q    <= 6'd0;
			presence_q <= 1'b0;
		end else if (step) begin
			phase_q    <= ph;
			timer_q    <= tt;
			bit_q      <= bi;
			shift_q    <= sh;
			left_q     <= bl;
			polls_q    <= pc;
			presence_q <= pf;
		end
	end

	always_comb begin
		res.drive_low  = drive;
		res.busy_res   = busy;
		res.done_res   = done;
		res.presence   = pf;
		res.read_byte  = rbyte;
		res.byte_valid = valid;
		res.last_byte  = last;
	end

endmodule

FILE: sv/one_wire_bus_master.sv
// Single-wire bus master driven one microsecond tick at a time.
// Each item on the req channel is one tick: the sampled bus level plus an
// optional command (reset with presence detect, write byte, read bytes,
// wait until ready). Each item yields exactly one item on the res channel
// with the bus drive for that tick, busy, done, presence and any byte read.
// Commands arriving while a command is in progress are ignored.
// Timing values come from eight registers on the cfg write port; write them
// only while no tick is in flight.
// An accepted item sits in the input register; the sequencer step then
// fills the result register, and the result is offered from there.
// Throughput is one item per cycle while res is not stalled; the sequencer
// state update is the only loop.
// When res is stalled the result register holds and one more item can be
// taken into the input register before req.ready drops.
// Reset clears the sequencer to idle, presence to zero, both pipeline
// stages to empty and the timing registers to 480, 60, 18, 10, 60, 15,
// 15 and 1.
`timescale 1ns / 1ps

module one_wire_bus_master (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_data,
	owm_req_if.sink                        req,
	owm_res_if.source                      res
);
	import owm_pkg::*;

	owm_cfg_t cfg;
	owm_req_t item_s1;
	logic     item_valid_s1;
	owm_res_t res_data_s2;
	logic     res_valid_s2;
	owm_res_t core_res;
	logic     out_adv;
	logic     step;
	logic     accept;

	assign out_adv   = !res_valid_s2 || res.ready;
	assign step      = item_valid_s1 && out_adv;
	assign req.ready = !item_valid_s1 || step;
	assign accept    = req.valid && req.ready;

	owm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			res_valid_s2  <= 1'b0;
		end else begin
			if (accept) begin
				item_valid_s1 <= 1'b1;
			end else if (step) begin
				item_valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				res_valid_s2 <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req.data;
		end
		if (step) begin
			res_data_s2 <= core_res;
		end
	end

	assign res.valid = res_valid_s2;
	assign res.data  = res_data_s2;

endmodule
